// ----- rtl/core/fexp_pkg.sv -----
package fexp_pkg;

    localparam int DEF_LANES  = 8;
    localparam int WORD_W     = 32;
    localparam int K_W        = 9;
    localparam int SIG_W      = 50;
    localparam int EXP_W      = 12;
    localparam int STAGES     = 18;
    localparam int POLY_STEPS = 10;
    localparam int POLY_FIRST = 7;

    localparam logic [31:0] CLAMP_HI    = 32'h42B0C0A5;
    localparam logic [31:0] CLAMP_LO    = 32'hC2B0C0A5;
    localparam logic [31:0] INV_LN2     = 32'h3FB8AA3B;
    localparam logic [31:0] LN2_HI      = 32'h3F318000;
    localparam logic [31:0] LN2_LO      = 32'hB95E8083;
    localparam logic [31:0] COEF5       = 32'h3C088889;
    localparam logic [31:0] ROUND_MAGIC = 32'h4B400000;
    localparam logic [31:0] NEG_MAGIC   = 32'hCB400000;
    localparam logic [31:0] DEFAULT_NAN = 32'hFFC00000;
    localparam logic [24:0] MAGIC_SIG   = 25'h0C00000;
    localparam logic signed [K_W-1:0] EXP_BIAS = 9'sd127;

    // added after the multiply steps of Horner's rule: c4, c3, c2, c1, c0
    localparam logic [31:0] POLY_ADD [5] = '{
        32'h3D2AAAAB, 32'h3E2AAAAB, 32'h3F000000, 32'h3F800000, 32'h3F800000
    };

    typedef struct packed {
        logic [STAGES-1:0] load;
    } pipe_ctrl_t;

    function automatic logic [SIG_W-1:0] shr_sticky(input logic [SIG_W-1:0] m,
                                                    input logic [EXP_W-1:0] amt);
        logic [SIG_W-1:0] mask;
        logic [SIG_W-1:0] res;
        if (amt >= EXP_W'(SIG_W))
            mask = '1;
        else
            mask = (SIG_W'(1) << amt) - SIG_W'(1);
        res = m >> amt;
        res[0] = res[0] | (|(m & mask));
        return res;
    endfunction

    // value = m * 2^e, m nonzero; normalize, denormalize if tiny, round to nearest even, overflow to infinity
    function automatic logic [31:0] fp_pack(input logic sign,
                                            input logic signed [EXP_W-1:0] e,
                                            input logic [SIG_W-1:0] m);
        logic [5:0] lz;
        logic [SIG_W-1:0] mn;
        logic [SIG_W-1:0] msh;
        logic signed [EXP_W-1:0] ebi;
        logic [7:0] ef;
        logic [30:0] base;
        logic guard;
        logic sticky;
        logic inc;
        logic [31:0] res;
        lz = '0;
        for (int i = 0; i < SIG_W; i++)
        begin
            if (m[i])
                lz = 6'(SIG_W - 1 - i);
        end
        mn  = m << lz;
        ebi = e + EXP_W'(SIG_W - 1 + 127) - $signed({6'd0, lz});
        if (ebi >= EXP_W'(255))
        begin
            res = {sign, 8'hFF, 23'd0};
        end
        else
        begin
            if (ebi <= 0)
            begin
                msh = shr_sticky(mn, EXP_W'(EXP_W'(1) - ebi));
                ef  = 8'd0;
            end
            else
            begin
                msh = mn;
                ef  = ebi[7:0];
            end
            guard  = msh[SIG_W-25];
            sticky = |msh[SIG_W-26:0];
            inc    = guard & (sticky | msh[SIG_W-24]);
            base   = {ef, msh[SIG_W-2 -: 23]};
            res    = {sign, base + 31'(inc)};
        end
        return res;
    endfunction

    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        logic s;
        logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        logic [7:0] ea, eb;
        logic [23:0] ma, mb;
        logic [47:0] p;
        logic signed [EXP_W-1:0] e;
        logic [31:0] res;
        s      = a[31] ^ b[31];
        a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
        b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
        a_zero = (a[30:0] == '0);
        b_zero = (b[30:0] == '0);
        ea     = (a[30:23] == '0) ? 8'd1 : a[30:23];
        eb     = (b[30:23] == '0) ? 8'd1 : b[30:23];
        ma     = {a[30:23] != '0, a[22:0]};
        mb     = {b[30:23] != '0, b[22:0]};
        p      = ma * mb;
        e      = $signed({4'd0, ea}) + $signed({4'd0, eb}) - EXP_W'(300);
        if (a_nan || b_nan)
            res = DEFAULT_NAN;
        else if ((a_inf && b_zero) || (b_inf && a_zero))
            res = DEFAULT_NAN;
        else if (a_inf || b_inf)
            res = {s, 8'hFF, 23'd0};
        else if (a_zero || b_zero)
            res = {s, 31'd0};
        else
            res = fp_pack(s, e, {2'b00, p});
        return res;
    endfunction

    function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
        logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        logic [31:0] big, sml;
        logic [7:0] eg, es;
        logic [SIG_W-1:0] mg, ms, sum;
        logic [31:0] res;
        a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
        b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
        a_zero = (a[30:0] == '0);
        b_zero = (b[30:0] == '0);
        big    = (a[30:0] >= b[30:0]) ? a : b;
        sml    = (a[30:0] >= b[30:0]) ? b : a;
        eg     = (big[30:23] == '0) ? 8'd1 : big[30:23];
        es     = (sml[30:23] == '0) ? 8'd1 : sml[30:23];
        mg     = {1'b0, big[30:23] != '0, big[22:0], 25'd0};
        ms     = shr_sticky({1'b0, sml[30:23] != '0, sml[22:0], 25'd0},
                            EXP_W'(eg - es));
        sum    = (a[31] == b[31]) ? (mg + ms) : (mg - ms);
        if (a_nan || b_nan)
            res = DEFAULT_NAN;
        else if (a_inf && b_inf && (a[31] != b[31]))
            res = DEFAULT_NAN;
        else if (a_inf)
            res = a;
        else if (b_inf)
            res = b;
        else if (a_zero && b_zero)
            res = {a[31] & b[31], 31'd0};
        else if (a_zero)
            res = b;
        else if (b_zero)
            res = a;
        else if (sum == '0)
            res = 32'd0;
        else
            res = fp_pack(big[31], $signed({4'd0, eg}) - EXP_W'(175), sum);
        return res;
    endfunction

    // a < b as IEEE compare, false on NaN
    function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
        logic a_nan, b_nan;
        logic res;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        if (a_nan || b_nan)
            res = 1'b0;
        else if ((a[30:0] == '0) && (b[30:0] == '0))
            res = 1'b0;
        else if (a[31] != b[31])
            res = a[31];
        else if (!a[31])
            res = a[30:0] < b[30:0];
        else
            res = a[30:0] > b[30:0];
        return res;
    endfunction

    function automatic logic [31:0] clamp(input logic [31:0] x);
        logic [31:0] v;
        v = f_lt(x, CLAMP_HI) ? x : CLAMP_HI;
        v = f_lt(CLAMP_LO, v) ? v : CLAMP_LO;
        return v;
    endfunction

    // x + 1.5*2^23 sits in [2^23, 2^24), so its significand minus the magic is k
    function automatic logic signed [K_W-1:0] magic_to_k(input logic [31:0] s);
        logic [24:0] t;
        t = {2'b01, s[22:0]} - MAGIC_SIG;
        return $signed(t[K_W-1:0]);
    endfunction

    function automatic logic [31:0] scale_of(input logic signed [K_W-1:0] k);
        logic signed [K_W-1:0] sum;
        sum = k + EXP_BIAS;
        return {sum, 23'd0};
    endfunction

endpackage

// ----- rtl/core/fexp_if.sv -----
interface fexp_if #(parameter int LANES = 8) ();
    logic                  valid;
    logic                  ready;
    logic [LANES*32-1:0]   lanes;
    logic                  group_last;

    modport source (output valid, output lanes, output group_last, input ready);
    modport sink   (input valid, input lanes, input group_last, output ready);
endinterface

// ----- rtl/core/fexp_ctrl.sv -----
module fexp_ctrl import fexp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_last,
    input  logic       out_ready,
    output logic       in_ready,
    output logic       out_valid,
    output logic       out_last,
    output pipe_ctrl_t ctl
);

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] adv;
    logic              last_reg [STAGES];

    // a stage moves when it is empty or the stage after it moves
    always_comb
    begin
        adv[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int s = STAGES - 2; s >= 0; s--)
            adv[s] = !vld_reg[s] || adv[s+1];
        vld_next = vld_reg;
        if (adv[0])
            vld_next[0] = in_valid;
        for (int s = 1; s < STAGES; s++)
        begin
            if (adv[s])
                vld_next[s] = vld_reg[s-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
            last_reg[0] <= in_last;
        for (int s = 1; s < STAGES; s++)
        begin
            if (adv[s])
                last_reg[s] <= last_reg[s-1];
        end
    end

    assign ctl.load  = adv;
    assign in_ready  = adv[0];
    assign out_valid = vld_reg[STAGES-1];
    assign out_last  = last_reg[STAGES-1];

endmodule

// ----- rtl/core/fexp_lane.sv -----
module fexp_lane import fexp_pkg::*;
(
    input  logic        clk,
    input  pipe_ctrl_t  ctl,
    input  logic [31:0] x,
    output logic [31:0] y
);

    logic [31:0] v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [31:0] s2_reg, s3_reg, kf4_reg, t1_reg, t2_reg, t2d_reg, r6_reg;
    logic signed [K_W-1:0] k4_reg, k5_reg, k6_reg;
    logic [31:0] pacc_reg [POLY_STEPS+1];
    logic [31:0] pr_reg   [POLY_STEPS+1];
    logic signed [K_W-1:0] pk_reg [POLY_STEPS+1];
    logic [31:0] pacc_next [POLY_STEPS+1];
    logic [31:0] y_reg;
    logic [31:0] y_next;

    // front: clamp, scale by 1/ln2, round to k, reduce the argument
    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
            v1_reg <= clamp(x);
        if (ctl.load[1])
        begin
            s2_reg <= fmul(v1_reg, INV_LN2);
            v2_reg <= v1_reg;
        end
        if (ctl.load[2])
        begin
            s3_reg <= fadd(s2_reg, ROUND_MAGIC);
            v3_reg <= v2_reg;
        end
        if (ctl.load[3])
        begin
            kf4_reg <= fadd(s3_reg, NEG_MAGIC);
            k4_reg  <= magic_to_k(s3_reg);
            v4_reg  <= v3_reg;
        end
        if (ctl.load[4])
        begin
            t1_reg <= fmul(kf4_reg, LN2_HI);
            t2_reg <= fmul(kf4_reg, LN2_LO);
            k5_reg <= k4_reg;
            v5_reg <= v4_reg;
        end
        if (ctl.load[5])
        begin
            r6_reg  <= fadd(v5_reg, {~t1_reg[31], t1_reg[30:0]});
            t2d_reg <= t2_reg;
            k6_reg  <= k5_reg;
        end
        if (ctl.load[6])
        begin
            pacc_reg[0] <= COEF5;
            pr_reg[0]   <= fadd(r6_reg, {~t2d_reg[31], t2d_reg[30:0]});
            pk_reg[0]   <= k6_reg;
        end
    end

    // Horner's rule: even steps multiply by r, odd steps add the next coefficient
    assign pacc_next[0] = pacc_reg[0];
    for (genvar j = 0; j < POLY_STEPS; j++)
    begin : g_poly
        if (j % 2 == 0)
        begin : g_mul
            assign pacc_next[j+1] = fmul(pacc_reg[j], pr_reg[j]);
        end
        else
        begin : g_add
            assign pacc_next[j+1] = fadd(pacc_reg[j], POLY_ADD[j/2]);
        end

        always_ff @(posedge clk)
        begin
            if (ctl.load[POLY_FIRST+j])
            begin
                pacc_reg[j+1] <= pacc_next[j+1];
                pr_reg[j+1]   <= pr_reg[j];
                pk_reg[j+1]   <= pk_reg[j];
            end
        end
    end

    assign y_next = fmul(scale_of(pk_reg[POLY_STEPS]), pacc_reg[POLY_STEPS]);

    always_ff @(posedge clk)
    begin
        if (ctl.load[STAGES-1])
            y_reg <= y_next;
    end

    assign y = y_reg;

endmodule

// ----- rtl/core/fast_exp_float32_lanes.sv -----
// channel   dir  payload                          handshake
// samples   in   lanes (LANES x 32b), group_last  valid / ready
// results   out  lanes (LANES x 32b), group_last  valid / ready
//
// One group per cycle while results is ready; each group passes a register stage for the clamp,
// for each step of the argument reduction and of Horner's rule, and for the final scaling.
// Reset clears only the stage valid bits; data registers are not reset.
// A stall at results fills empty stages first, so samples keeps taking
// requests until every stage holds a group.
module fast_exp_float32_lanes import fexp_pkg::*;
#(
    parameter int LANES = DEF_LANES
)
(
    input logic    clk,
    input logic    rst_n,
    fexp_if.sink   samples,
    fexp_if.source results
);

    pipe_ctrl_t          ctl;
    logic [LANES*32-1:0] y_all;

    fexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_last   (samples.group_last),
        .out_ready (results.ready),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_last  (results.group_last),
        .ctl       (ctl)
    );

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        fexp_lane u_lane (
            .clk (clk),
            .ctl (ctl),
            .x   (samples.lanes[i*WORD_W +: WORD_W]),
            .y   (y_all[i*WORD_W +: WORD_W])
        );
    end

    assign results.lanes = y_all;

    a_empty_out_ready : assert property (@(posedge clk) disable iff (!rst_n)
        !results.valid |-> samples.ready)
        else $error("input stalled with empty output stage");

    a_flow_through : assert property (@(posedge clk) disable iff (!rst_n)
        results.ready |-> samples.ready)
        else $error("input stalled while output drains");

    a_all_load : assert property (@(posedge clk) disable iff (!rst_n)
        results.ready |-> (ctl.load == '1))
        else $error("pipeline stage held while output drains");

endmodule
